### rtl/mcs_pkg.sv
package mcs_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_LIMIT = (MAX_SIDE < 64) ? MAX_SIDE : 64;
  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CELL_W     = 9;
  localparam int NREADS     = 5;
  localparam int RSEL_W     = $clog2(NREADS);

  typedef enum logic [1:0] {
    CMD_CARVE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MARK_UNVISITED = 2'd0,
    MARK_ACTIVE    = 2'd1,
    MARK_DONE      = 2'd2,
    MARK_SPARE     = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_E = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  localparam logic [2:0] EDGE_MAX = 3'd4;

  typedef struct packed {
    logic [2:0] edges;
    logic [3:0] walls;
    logic [1:0] mark;
  } cell_t;

  localparam cell_t CELL_RESET = '{edges: 3'd0, walls: 4'hf, mark: MARK_UNVISITED};

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] random_pick;
    logic [1:0] mark_in;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] new_row;
    logic [5:0] new_col;
    logic [1:0] direction;
    logic [1:0] cell_mark;
    logic [3:0] wall_bits;
    logic [2:0] edge_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PICK,
    S_WR_CUR,
    S_WR_NB,
    S_DONE
  } state_t;

endpackage

### rtl/mcs_ram.sv
module mcs_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/maze_carve_step.sv
// Maze carving step engine.
// Input channel (in_valid/in_stall/in_item) takes one command item at a time:
// carve step, read cell or write visit mark, addressed by row and col.
// Output channel (out_valid/out_stall/out_item) returns exactly one result
// item per command, in order, from an output register.
// Configuration: cfg_we writes cfg_data into grid_rows (index 0) or
// grid_cols (index 1); writes are taken in any cycle.
// Steps: a carve step inside the grid reads its cells, picks a neighbour and
// writes the current cell, then the carved neighbour if any; a read reads the
// cell, a mark write reads then writes it; commands outside the grid or unused
// go straight to the result; the next item is taken the cycle after it loads.
// The single read port of the cell RAM sets these steps: a carve step reads
// the current cell and its four neighbours one per cycle, then writes the
// current cell and any carved neighbour one per cycle via the single write port.
// A new item is accepted once the previous result is in the output register,
// even if that result is still stalled; a result waits in its final state
// while the output register is occupied and stalled.
// Reset (rst, synchronous): the RAM is swept to its cleared value, one cell a
// cycle, over all MAX_SIDE*MAX_SIDE (4096) cells; in_stall is high throughout.
module maze_carve_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcs_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output mcs_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  import mcs_pkg::*;

  state_t              state, state_next;
  logic [6:0]          grid_rows, grid_cols;
  logic [6:0]          rows, cols;
  in_item_t            item;
  logic [ADDR_W-1:0]   clr_addr;
  logic [RSEL_W-1:0]   rd_sel, rd_last;
  logic                rd_pend;
  logic [RSEL_W-1:0]   rd_tag;
  cell_t               cells [NREADS];
  cell_t               nb_cell;
  logic                found_r;
  logic [1:0]          dir_r;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  cell_t               ram_wdata, ram_rdata;
  logic [3:0]          bounds, cand;
  logic                pick_found;
  logic [1:0]          pick_dir;
  logic                item_inside, in_inside;
  logic [11:0]         nb_pos;
  logic                out_load;
  out_item_t           out_item_next;

  function automatic logic [6:0] clamp_side(logic [6:0] v);
    if (v == 7'd0) begin
      return 7'd1;
    end else if (v > 7'(SIDE_LIMIT)) begin
      return 7'(SIDE_LIMIT);
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [5:0] r, logic [5:0] c);
    logic [ADDR_W+6:0] a;
    a = (ADDR_W+7)'(r) * (ADDR_W+7)'(MAX_SIDE) + (ADDR_W+7)'(c);
    return a[ADDR_W-1:0];
  endfunction

  // {row, col} of the neighbour in direction d
  function automatic logic [11:0] step_pos(logic [5:0] r, logic [5:0] c, logic [1:0] d);
    case (d)
      DIR_N:   return {r - 6'd1, c};
      DIR_S:   return {r + 6'd1, c};
      DIR_E:   return {r, c + 6'd1};
      DIR_W:   return {r, c - 6'd1};
      default: return {r, c};
    endcase
  endfunction

  function automatic logic [1:0] back_dir(logic [1:0] d);
    case (d)
      DIR_N:   return DIR_S;
      DIR_S:   return DIR_N;
      DIR_E:   return DIR_W;
      DIR_W:   return DIR_E;
      default: return DIR_S;
    endcase
  endfunction

  function automatic cell_t open_wall(cell_t v, logic [1:0] d);
    cell_t o;
    o = v;
    o.walls[d] = 1'b0;
    if (v.edges < EDGE_MAX) begin
      o.edges = v.edges + 3'd1;
    end
    return o;
  endfunction

  // 8-bit value mod 3: base-4 digit sum, then a small table
  function automatic logic [1:0] mod3(logic [7:0] p);
    logic [3:0] s;
    s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: return 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       return 2'd1;
      default:                       return 2'd2;
    endcase
  endfunction

  assign rows = clamp_side(grid_rows);
  assign cols = clamp_side(grid_cols);

  assign in_inside   = ({1'b0, in_item.row} < rows) && ({1'b0, in_item.col} < cols);
  assign item_inside = ({1'b0, item.row} < rows) && ({1'b0, item.col} < cols);

  assign bounds[DIR_N] = item.row != 6'd0;
  assign bounds[DIR_S] = ({1'b0, item.row} + 7'd1) < rows;
  assign bounds[DIR_E] = ({1'b0, item.col} + 7'd1) < cols;
  assign bounds[DIR_W] = item.col != 6'd0;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand[k] = bounds[k] && (cells[0].mark == MARK_ACTIVE) &&
                (cells[k+1].mark == MARK_UNVISITED);
    end
  end

  always_comb begin
    logic [2:0] n;
    logic [1:0] sel;
    logic [1:0] seen;
    n = 3'($countones(cand));
    case (n)
      3'd2:    sel = {1'b0, item.random_pick[0]};
      3'd3:    sel = mod3(item.random_pick);
      3'd4:    sel = item.random_pick[1:0];
      default: sel = 2'd0;
    endcase
    pick_found = n != 3'd0;
    pick_dir   = DIR_N;
    seen       = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand[k]) begin
        if (seen == sel) begin
          pick_dir = 2'(k);
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign rd_last = (item.command == CMD_CARVE) ? RSEL_W'(NREADS - 1) : '0;
  assign nb_pos  = step_pos(item.row, item.col, dir_r);
  assign out_load = !out_valid || !out_stall;

  mcs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_inside && (in_item.command != CMD_NONE)) state_next = S_READ;
          else state_next = S_DONE;
        end
      end
      S_READ: begin
        if (rd_sel == rd_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        case (item.command)
          CMD_CARVE: state_next = S_PICK;
          CMD_MARK:  state_next = S_WR_CUR;
          default:   state_next = S_DONE;
        endcase
      end
      S_PICK:   state_next = S_WR_CUR;
      S_WR_CUR: begin
        if ((item.command == CMD_CARVE) && found_r) state_next = S_WR_NB;
        else state_next = S_DONE;
      end
      S_WR_NB:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    logic [11:0] rp;
    in_stall  = state != S_IDLE;
    ram_we    = 1'b0;
    ram_waddr = cell_addr(item.row, item.col);
    ram_wdata = cells[0];
    if (rd_sel == '0) begin
      rp = {item.row, item.col};
    end else begin
      rp = step_pos(item.row, item.col, 2'(rd_sel - RSEL_W'(1)));
    end
    ram_raddr = cell_addr(rp[11:6], rp[5:0]);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = CELL_RESET;
      end
      S_WR_CUR: begin
        ram_we = 1'b1;
        if (item.command == CMD_MARK) begin
          ram_wdata.mark = (item.mark_in == MARK_SPARE) ? MARK_DONE : item.mark_in;
        end else if (found_r) begin
          ram_wdata = open_wall(cells[0], dir_r);
        end else begin
          ram_wdata.mark = MARK_DONE;
        end
      end
      S_WR_NB: begin
        ram_we         = 1'b1;
        ram_waddr      = cell_addr(nb_pos[11:6], nb_pos[5:0]);
        ram_wdata      = open_wall(nb_cell, back_dir(dir_r));
        ram_wdata.mark = MARK_ACTIVE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_item_next         = '0;
    out_item_next.new_row = item.row;
    out_item_next.new_col = item.col;
    if ((item.command == CMD_CARVE) && found_r) begin
      out_item_next.found     = 1'b1;
      out_item_next.new_row   = nb_pos[11:6];
      out_item_next.new_col   = nb_pos[5:0];
      out_item_next.direction = dir_r;
    end
    if ((item.command == CMD_READ) && item_inside) begin
      out_item_next.cell_mark  = cells[0].mark;
      out_item_next.wall_bits  = cells[0].walls;
      out_item_next.edge_count = cells[0].edges;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
      rd_sel    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= state == S_READ;
      if (state == S_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) grid_rows <= cfg_data;
        else grid_cols <= cfg_data;
      end
      if ((state == S_IDLE) && in_valid) begin
        rd_sel  <= '0;
        found_r <= 1'b0;
      end else if (state == S_READ) begin
        rd_sel <= rd_sel + RSEL_W'(1);
      end
      if (state == S_PICK) found_r <= pick_found;
      if ((state == S_DONE) && out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) item <= in_item;
    rd_tag <= rd_sel;
    if (rd_pend) cells[rd_tag] <= ram_rdata;
    if (state == S_PICK) begin
      dir_r   <= pick_dir;
      nb_cell <= cells[3'(pick_dir) + 3'd1];
    end
    if ((state == S_DONE) && out_load) out_item <= out_item_next;
  end

`ifndef ASSERT_OFF
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_WR_CUR || state == S_WR_NB))
    else $error("cell RAM written outside a write state");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result shown during clearing sweep");

  a_nb_found: assert property (@(posedge clk) disable iff (rst)
    state == S_WR_NB |-> found_r && item.command == CMD_CARVE)
    else $error("neighbour write without a carved step");

  a_found_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.found |->
      out_item.cell_mark == 2'd0 && out_item.wall_bits == 4'd0 &&
      out_item.edge_count == 3'd0)
    else $error("carve result carries read fields");

  a_pick_enter: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> $past(state) == S_DRAIN && !rd_pend)
    else $error("pick entered before all reads landed");
`endif

endmodule
